@@ hw/rtl/lru_page_replacement_core_macros.svh @@
// Assertion macros for the LRU page replacement core.
// Taken in by the modules that check their own logic; uses clk and rst_n.
`ifndef LRU_PAGE_REPLACEMENT_CORE_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_CORE_MACROS_SVH

// Condition that must hold at every edge out of reset
`define LRUPR_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("lrupr: assertion failed");

// Same-cycle implication
`define LRUPR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrupr: assertion failed");

// Next-cycle implication
`define LRUPR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrupr: assertion failed");

`endif

@@ hw/rtl/lrupr_pkg.sv @@
// Shared constants and types for the LRU page replacement core.
// No dependencies; imported by the register block, frame table and top level.
`timescale 1ns / 1ps

package lrupr_pkg;

    // Configuration port geometry
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_FRAMES_IN_USE = 1'b0;

    // Frame limit register
    localparam int                      FRAMES_IN_USE_W     = 4;
    localparam logic [FRAMES_IN_USE_W-1:0] FRAMES_IN_USE_RESET = 4'd4;

    // Miss counter
    localparam int               MISS_W   = 32;
    localparam logic [MISS_W-1:0] MISS_MAX = '1;

    // Outcome flags of one lookup
    typedef struct packed {
        logic hit;
        logic evicted_valid;
    } lrupr_flags_t;

endpackage

@@ hw/rtl/lrupr_req_if.sv @@
// Page reference channel: valid/ready handshake carrying one page number.
// No dependencies.
`timescale 1ns / 1ps

interface lrupr_req_if #(
    parameter int PAGE_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic [PAGE_BITS-1:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);
endinterface

@@ hw/rtl/lrupr_rsp_if.sv @@
// Lookup result channel: valid/ready handshake carrying hit, eviction and miss count.
// No dependencies.
`timescale 1ns / 1ps

interface lrupr_rsp_if #(
    parameter int PAGE_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic                 evicted_valid;
    logic [PAGE_BITS-1:0] evicted_page;
    logic [31:0]          miss_total;

    modport source (output valid, output hit, output evicted_valid, output evicted_page,
                    output miss_total, input ready);
    modport sink   (input valid, input hit, input evicted_valid, input evicted_page,
                    input miss_total, output ready);
endinterface

@@ hw/rtl/lrupr_cfg_regs.sv @@
// APB-style configuration register block holding the frame limit.
// Depends on lrupr_pkg.
`timescale 1ns / 1ps

module lrupr_cfg_regs
    import lrupr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [APB_ADDR_W-1:0]      paddr,
    input  logic [APB_DATA_W-1:0]      pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready,
    output logic [FRAMES_IN_USE_W-1:0] frames_in_use
);

    logic [FRAMES_IN_USE_W-1:0] frames_reg;
    logic [FRAMES_IN_USE_W-1:0] frames_next;
    logic [REG_IDX_W-1:0]       reg_idx;
    logic                       wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Decode writes
    always_comb
    begin
        frames_next = frames_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_FRAMES_IN_USE: frames_next = pwdata[FRAMES_IN_USE_W-1:0];
                default:           frames_next = frames_reg;
            endcase
        end
    end

    // Decode reads
    always_comb
    begin
        unique case (reg_idx)
            REG_FRAMES_IN_USE: prdata = APB_DATA_W'(frames_reg);
            default:           prdata = '0;
        endcase
    end

    // Hold the limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg <= FRAMES_IN_USE_RESET;
        end
        else
        begin
            frames_reg <= frames_next;
        end
    end

    assign frames_in_use = frames_reg;

endmodule

@@ hw/rtl/lrupr_frame_table.sv @@
// Fully associative frame table: combinational parallel tag compare, LRU victim
// pick and rank update, plus the saturating miss counter. Depends on lrupr_pkg.
`timescale 1ns / 1ps
`include "lru_page_replacement_core_macros.svh"

module lrupr_frame_table
    import lrupr_pkg::*;
#(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       lookup_en,
    input  logic [PAGE_BITS-1:0]       page,
    input  logic [FRAMES_IN_USE_W-1:0] frames_in_use,
    output lrupr_flags_t               flags,
    output logic [PAGE_BITS-1:0]       evicted_page,
    output logic [MISS_W-1:0]          miss_total
);

    localparam int RANK_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam logic [MAX_FRAMES-1:0] FRAME_ONE = MAX_FRAMES'(1);

    // Frame state
    logic [PAGE_BITS-1:0]  page_reg [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] valid_reg;
    logic [MAX_FRAMES-1:0] valid_next;
    logic [RANK_W-1:0]     rank_reg  [MAX_FRAMES];
    logic [RANK_W-1:0]     rank_next [MAX_FRAMES];
    logic [MISS_W-1:0]     miss_reg;
    logic [MISS_W-1:0]     miss_next;

    // Lookup terms
    logic [MAX_FRAMES-1:0] active;
    logic [MAX_FRAMES-1:0] match;
    logic [MAX_FRAMES-1:0] empty;
    logic [MAX_FRAMES-1:0] is_max;
    logic [MAX_FRAMES-1:0] hit_oh;
    logic [MAX_FRAMES-1:0] fill_oh;
    logic [MAX_FRAMES-1:0] evict_oh;
    logic [MAX_FRAMES-1:0] target_oh;
    logic                  any_hit;
    logic                  any_empty;
    logic                  raise_all;
    logic [RANK_W-1:0]     bound;
    logic [PAGE_BITS-1:0]  target_page;

    // Compare every frame below the limit; find empties and the oldest active frame
    always_comb
    begin
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            active[i] = (i == 0) || (32'(i) < 32'(frames_in_use));
            match[i]  = valid_reg[i] && active[i] && (page_reg[i] == page);
            empty[i]  = active[i] && !valid_reg[i];
            is_max[i] = active[i];
            for (int j = 0; j < MAX_FRAMES; j++)
            begin
                if (active[j] && (rank_reg[j] > rank_reg[i]))
                begin
                    is_max[i] = 1'b0;
                end
            end
        end
    end

    // Pick the lowest-indexed candidate of each kind
    assign hit_oh   = match  & (~match  + FRAME_ONE);
    assign fill_oh  = empty  & (~empty  + FRAME_ONE);
    assign evict_oh = is_max & (~is_max + FRAME_ONE);

    assign any_hit   = |match;
    assign any_empty = |empty;
    assign raise_all = !any_hit && any_empty;

    always_comb
    begin
        if (any_hit)
        begin
            target_oh = hit_oh;
        end
        else if (any_empty)
        begin
            target_oh = fill_oh;
        end
        else
        begin
            target_oh = evict_oh;
        end
    end

    // Read the target frame's rank and page
    always_comb
    begin
        bound       = '0;
        target_page = '0;
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            if (target_oh[i])
            begin
                bound       = bound | rank_reg[i];
                target_page = target_page | page_reg[i];
            end
        end
    end

    // Make the target most recent and age the frames that were newer
    always_comb
    begin
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            if (target_oh[i])
            begin
                rank_next[i] = '0;
            end
            else if (valid_reg[i] && (raise_all || (rank_reg[i] < bound)))
            begin
                rank_next[i] = rank_reg[i] + RANK_W'(1);
            end
            else
            begin
                rank_next[i] = rank_reg[i];
            end
        end
    end

    assign valid_next = valid_reg | (any_hit ? '0 : target_oh);
    assign miss_next  = (!any_hit && (miss_reg != MISS_MAX)) ? miss_reg + MISS_W'(1)
                                                             : miss_reg;

    // Result of this transaction
    assign flags.hit           = any_hit;
    assign flags.evicted_valid = !any_hit && !any_empty;
    assign evicted_page        = flags.evicted_valid ? target_page : '0;
    assign miss_total          = miss_next;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            miss_reg  <= '0;
            for (int i = 0; i < MAX_FRAMES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else if (lookup_en)
        begin
            valid_reg <= valid_next;
            miss_reg  <= miss_next;
            for (int i = 0; i < MAX_FRAMES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    // Page tags: written on a miss into the target frame
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            if (lookup_en && !any_hit && target_oh[i])
            begin
                page_reg[i] <= page;
            end
        end
    end

    `LRUPR_ASSERT_IMPL(a_target_onehot, lookup_en, $onehot(target_oh))
    `LRUPR_ASSERT_NEXT(a_miss_fills_target, lookup_en && !any_hit, |(valid_reg & $past(target_oh)))
    `LRUPR_ASSERT_NEXT(a_idle_holds_state, !lookup_en, $stable(miss_reg) && $stable(valid_reg))
    `LRUPR_ASSERT_NEXT(a_miss_count_rises, lookup_en, miss_reg >= $past(miss_reg))

endmodule

@@ hw/rtl/lru_page_replacement_core.sv @@
// LRU page replacement core, top level.
// Channels: req carries one page number per transaction (valid/ready); rsp
// returns exactly one result per reference: hit, evicted_valid, evicted_page
// and the saturating miss total including this reference.
// The frame limit (frames_in_use, 1..MAX_FRAMES, 0 acts as 1) is written over
// the APB-style port at byte address 0; write it only while the core is idle.
// Throughput: one reference per cycle while results are taken. Each reference reads
// and updates the whole frame table (compare, victim pick, rank update)
// combinationally between the input register and the result register.
// Path: an accepted reference waits in the input register, moves to the result
// register once that is free or being taken, and is offered on rsp from there.
// Reset: all frames empty, ranks and miss total zero, frame limit 4.
// Stall: while rsp.ready is low the result is held; one more reference can
// wait in the input register, then req.ready drops until rsp is taken.
// Depends on lrupr_pkg, lrupr_req_if, lrupr_rsp_if, lrupr_cfg_regs, lrupr_frame_table.
`timescale 1ns / 1ps

module lru_page_replacement_core
    import lrupr_pkg::*;
#(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    lrupr_req_if.sink             req,
    lrupr_rsp_if.source           rsp
);

    logic [FRAMES_IN_USE_W-1:0] frames_in_use;

    // Input register
    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [PAGE_BITS-1:0] in_page_reg;

    // Result register
    logic                 out_valid_reg;
    logic                 out_valid_next;
    lrupr_flags_t         out_flags_reg;
    logic [PAGE_BITS-1:0] out_evicted_reg;
    logic [MISS_W-1:0]    out_miss_reg;

    // Frame table result
    lrupr_flags_t         flags;
    logic [PAGE_BITS-1:0] evicted_page;
    logic [MISS_W-1:0]    miss_total;

    logic advance;
    logic lookup_en;
    logic take_in;

    lrupr_cfg_regs u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .frames_in_use (frames_in_use)
    );

    lrupr_frame_table #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_table (
        .clk           (clk),
        .rst_n         (rst_n),
        .lookup_en     (lookup_en),
        .page          (in_page_reg),
        .frames_in_use (frames_in_use),
        .flags         (flags),
        .evicted_page  (evicted_page),
        .miss_total    (miss_total)
    );

    // Advance when the result register is free or being taken
    assign advance   = !out_valid_reg || rsp.ready;
    assign lookup_en = in_valid_reg && advance;
    assign req.ready = !in_valid_reg || advance;
    assign take_in   = req.valid && req.ready;

    assign in_valid_next  = take_in || (in_valid_reg && !advance);
    assign out_valid_next = lookup_en || (out_valid_reg && !rsp.ready);

    // Handshake state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_page_reg <= req.page_number;
        end
        if (lookup_en)
        begin
            out_flags_reg   <= flags;
            out_evicted_reg <= evicted_page;
            out_miss_reg    <= miss_total;
        end
    end

    // Drive the result channel
    assign rsp.valid         = out_valid_reg;
    assign rsp.hit           = out_flags_reg.hit;
    assign rsp.evicted_valid = out_flags_reg.evicted_valid;
    assign rsp.evicted_page  = out_evicted_reg;
    assign rsp.miss_total    = out_miss_reg;

endmodule

@@ test/lru_page_replacement_core_tb.sv @@
// Testbench for the LRU page replacement core: sends page references under random
// idling and back-pressure, predicts hit, eviction and miss total, and checks each result.
// Depends on lrupr_pkg, lrupr_req_if, lrupr_rsp_if and the lru_page_replacement_core RTL.
`timescale 1ns / 1ps

module lru_page_replacement_core_tb;
    import lrupr_pkg::*;

    localparam int MAX_FRAMES     = 8;
    localparam int PAGE_BITS      = 16;
    localparam int RANK_W         = 3;
    localparam int GAP_MAX        = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 80;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_REFS     = 100;
    localparam int POOL_MAX       = 12;

    // Expected outcome of one page reference
    typedef struct packed {
        lrupr_flags_t         flags;
        logic [PAGE_BITS-1:0] evicted_page;
        logic [MISS_W-1:0]    miss_total;
    } lookup_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    lrupr_req_if #(.PAGE_BITS(PAGE_BITS)) req_ch ();
    lrupr_rsp_if #(.PAGE_BITS(PAGE_BITS)) rsp_ch ();

    lru_page_replacement_core #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    // Shadow frame table
    logic [PAGE_BITS-1:0]       shadow_page  [MAX_FRAMES];
    logic                       shadow_valid [MAX_FRAMES];
    logic [RANK_W-1:0]          shadow_rank  [MAX_FRAMES];
    logic [MISS_W-1:0]          shadow_misses;
    logic [FRAMES_IN_USE_W-1:0] shadow_limit;

    lookup_t pending_lookups [$];

    int error_count;
    int refs_sent;
    int hits_predicted;
    int evictions_predicted;
    int limit_writes;
    bit idle_on;
    int rsp_hold_cycles;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Frame limit as the core applies it: 0 acts as 1, above MAX_FRAMES clamps
    function automatic int usable_frames();
        if (shadow_limit == '0)
            return 1;
        if (int'(shadow_limit) > MAX_FRAMES)
            return MAX_FRAMES;
        return int'(shadow_limit);
    endfunction

    // Make frame f the most recent; valid ranks below bound age by one
    function automatic void make_recent(input int f, input int bound);
        int i;
        for (i = 0; i < MAX_FRAMES; i++)
            if (i != f && shadow_valid[i] && int'(shadow_rank[i]) < bound)
                shadow_rank[i] = shadow_rank[i] + 1'b1;
        shadow_rank[f] = '0;
    endfunction

    // Look up one page, update the shadow table and return the expected result
    function automatic lookup_t lookup_page(input logic [PAGE_BITS-1:0] page);
        lookup_t res;
        int      lim;
        int      target;
        int      worst;
        int      i;
        bit      found;
        bit      empty;
        res    = '0;
        lim    = usable_frames();
        target = 0;
        found  = 1'b0;
        empty  = 1'b0;
        // Lowest-indexed match wins when a page sits in two frames
        for (i = 0; i < lim; i++)
            if (!found && shadow_valid[i] && shadow_page[i] == page)
            begin
                target = i;
                found  = 1'b1;
            end
        if (found)
        begin
            make_recent(target, int'(shadow_rank[target]));
        end
        else
        begin
            if (shadow_misses != MISS_MAX)
                shadow_misses = shadow_misses + 1'b1;
            for (i = 0; i < lim; i++)
                if (!empty && !shadow_valid[i])
                begin
                    target = i;
                    empty  = 1'b1;
                end
            if (empty)
            begin
                shadow_valid[target] = 1'b1;
                shadow_page[target]  = page;
                make_recent(target, MAX_FRAMES);
            end
            else
            begin
                // Evict the oldest frame below the limit
                target = 0;
                worst  = int'(shadow_rank[0]);
                for (i = 1; i < lim; i++)
                    if (int'(shadow_rank[i]) > worst)
                    begin
                        target = i;
                        worst  = int'(shadow_rank[i]);
                    end
                res.flags.evicted_valid = 1'b1;
                res.evicted_page        = shadow_page[target];
                shadow_page[target]     = page;
                make_recent(target, worst);
                evictions_predicted++;
            end
        end
        if (found)
            hits_predicted++;
        res.flags.hit  = found;
        res.miss_total = shadow_misses;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
        error_count++;
    endtask

    // Offer one page reference and hold it until the core takes it
    task automatic send_page(input logic [PAGE_BITS-1:0] page);
        int gap;
        gap = idle_on ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.page_number <= page;
        do @(posedge clk); while (!req_ch.ready);
        pending_lookups = {pending_lookups, lookup_page(page)};
        refs_sent++;
    endtask

    // Stop offering and wait until every expected result has been taken
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
    endtask

    // Write the frame limit over the register port; upper data bits are noise
    task automatic write_frame_limit(input logic [FRAMES_IN_USE_W-1:0] value);
        logic [APB_DATA_W-1:0] data;
        data                      = $urandom();
        data[FRAMES_IN_USE_W-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_FRAMES_IN_USE, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_limit = value;
        limit_writes++;
    endtask

    // Reset limit of four: fill from empty, hits, then replacement
    task automatic test_fill_and_replace();
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h1234);
        send_page(16'h0000);
        send_page(16'hABCD);
        send_page(16'h5555);
        send_page(16'h1234);
        send_page(16'hAAAA);
        send_page(16'hAAAA);
        send_page(16'hFFFF);
    endtask

    // Limit extremes, out-of-range values, and stale copies above a lowered limit
    task automatic test_frame_limits();
        wait_drained();
        write_frame_limit(4'd8);
        send_page(16'h0100);
        send_page(16'h0101);
        send_page(16'h0102);
        send_page(16'h0103);
        send_page(16'h0104);
        wait_drained();
        write_frame_limit(4'd0);
        send_page(16'h0103);
        send_page(16'h0103);
        wait_drained();
        write_frame_limit(4'd15);
        send_page(16'h0103);
        send_page(16'h0200);
        wait_drained();
        write_frame_limit(4'd2);
        send_page(16'hFFFF);
        send_page(16'h0000);
    endtask

    // Hold the result side for a long stretch while references keep coming
    task automatic test_backpressure();
        int n;
        wait_drained();
        write_frame_limit(4'd3);
        idle_on         = 1'b0;
        rsp_hold_cycles = LONG_HOLD;
        for (n = 0; n < 16; n++)
            send_page(16'h0300 + PAGE_BITS'(n % 5));
        wait_drained();
        idle_on = 1'b1;
    endtask

    // Working-set traffic with some noise, one frame limit per phase
    task automatic test_random_refs();
        logic [PAGE_BITS-1:0]       pool [POOL_MAX];
        logic [FRAMES_IN_USE_W-1:0] lim;
        int                         pool_size;
        int                         phase;
        int                         n;
        bit                         sweep;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_drained();
            case (phase)
                0:       lim = 4'd1;
                1:       lim = 4'd8;
                2:       lim = 4'd0;
                3:       lim = 4'd15;
                default: lim = FRAMES_IN_USE_W'($urandom_range(0, 15));
            endcase
            write_frame_limit(lim);
            idle_on   = ($urandom_range(0, 3) != 0);
            pool_size = $urandom_range(2, POOL_MAX);
            for (n = 0; n < pool_size; n++)
                pool[n] = PAGE_BITS'($urandom_range(0, 16'hFFFF));
            sweep = ($urandom_range(0, 3) == 0);
            for (n = 0; n < PHASE_REFS; n++)
            begin
                if ($urandom_range(0, 99) < 15)
                    send_page(PAGE_BITS'($urandom_range(0, 16'hFFFF)));
                else if (sweep)
                    send_page(pool[n % pool_size]);
                else
                    send_page(pool[$urandom_range(0, pool_size - 1)]);
            end
        end
        idle_on = 1'b1;
    endtask

    // Take each result after a random stall and compare it with the oldest expectation
    initial
    begin : result_checker
        int      stall;
        lookup_t want;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rsp_hold_cycles > 0)
            begin
                stall           = rsp_hold_cycles;
                rsp_hold_cycles = 0;
            end
            else
            begin
                stall = idle_on ? $urandom_range(0, GAP_MAX) : 0;
            end
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (rsp_ch.valid !== 1'b1);
            if (pending_lookups.size() == 0)
            begin
                report_mismatch("unexpected result, miss_total", rsp_ch.miss_total, 0);
            end
            else
            begin
                want = pending_lookups.pop_front();
                if (rsp_ch.hit !== want.flags.hit)
                    report_mismatch("hit", rsp_ch.hit, want.flags.hit);
                if (rsp_ch.evicted_valid !== want.flags.evicted_valid)
                    report_mismatch("evicted_valid", rsp_ch.evicted_valid,
                                    want.flags.evicted_valid);
                if (rsp_ch.evicted_page !== want.evicted_page)
                    report_mismatch("evicted_page", rsp_ch.evicted_page, want.evicted_page);
                if (rsp_ch.miss_total !== want.miss_total)
                    report_mismatch("miss_total", rsp_ch.miss_total, want.miss_total);
            end
        end
    end

    // End the run when no transaction has moved for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("lru_page_replacement_core_tb: done, errors");
        $finish;
    end

    // Reset, run each test in turn, then drain and report
    initial
    begin : stimulus
        int i;
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        req_ch.valid       = 1'b0;
        req_ch.page_number = '0;
        idle_on            = 1'b1;
        rsp_hold_cycles    = 0;
        error_count        = 0;
        refs_sent          = 0;
        hits_predicted     = 0;
        evictions_predicted = 0;
        limit_writes       = 0;
        for (i = 0; i < MAX_FRAMES; i++)
        begin
            shadow_page[i]  = '0;
            shadow_valid[i] = 1'b0;
            shadow_rank[i]  = '0;
        end
        shadow_misses = '0;
        shadow_limit  = FRAMES_IN_USE_RESET;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_and_replace();
        test_frame_limits();
        test_backpressure();
        test_random_refs();

        wait_drained();
        repeat (4) @(posedge clk);
        $display("covered %0d references: %0d hits, %0d evictions, %0d misses",
                 refs_sent, hits_predicted, evictions_predicted, shadow_misses);
        $display("frame limit written %0d times, extremes and out-of-range values included",
                 limit_writes);
        if (error_count == 0)
            $display("lru_page_replacement_core_tb: done, clean");
        else
            $display("lru_page_replacement_core_tb: done, errors");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/lrupr_pkg.sv
hw/rtl/lrupr_req_if.sv
hw/rtl/lrupr_rsp_if.sv
hw/rtl/lrupr_cfg_regs.sv
hw/rtl/lrupr_frame_table.sv
hw/rtl/lru_page_replacement_core.sv
test/lru_page_replacement_core_tb.sv
